// ----- design/clcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants for the character display controller.
// ----------------------------------------------------------------------------
package clcd_pkg;

    localparam int CELLS_PER_LINE_DEF = 16;
    localparam int MAX_OFFSET_DEF     = 24;

    localparam logic [1:0] ACT_INSTR = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_LOAD  = 2'd3;

    localparam logic [6:0] LINE2_BASE = 7'h40;
    localparam logic [6:0] LINE1_LAST = 7'h27;
    localparam logic [6:0] LINE2_LAST = 7'h67;
    localparam logic [7:0] BLANK_CODE = 8'h20;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] value;
        logic [4:0] cell_req;
        logic [2:0] pixel_row;
        logic [7:0] char_code;
        logic       blink_phase;
    } cmd_t;

endpackage

// ----- design/clcd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module clcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read at the same address; the read returns the old contents
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- design/clcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_front
// Accepts transactions into a two-entry queue toward the execution engine.
// ----------------------------------------------------------------------------
module clcd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  clcd_pkg::cmd_t in_cmd,
    output logic          q_valid,
    input  logic          q_pop,
    output clcd_pkg::cmd_t q_cmd
);
    import clcd_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];

    // Store payload
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ----- design/clcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_back
// Executes commands: register updates, memory writes, pixel row reads,
// clear sweep and clear-after-reset sweeps.
// ----------------------------------------------------------------------------
module clcd_back #(
    parameter int CELLS_PER_LINE = clcd_pkg::CELLS_PER_LINE_DEF,
    parameter int MAX_OFFSET     = clcd_pkg::MAX_OFFSET_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_pop,
    input  clcd_pkg::cmd_t q_cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [4:0]     m_row_bits,
    output logic [6:0]     m_address_counter
);
    import clcd_pkg::*;

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_EXEC  = 4'd2;
    localparam logic [3:0] ST_RD1   = 4'd3;
    localparam logic [3:0] ST_RD2   = 4'd4;
    localparam logic [3:0] ST_RD3   = 4'd5;
    localparam logic [3:0] ST_CLR   = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    localparam logic [5:0] MAXOFF = 6'(MAX_OFFSET);
    localparam logic [7:0] NCELL  = 8'(CELLS_PER_LINE);

    logic [3:0]  state_reg;
    logic [10:0] sweep_reg;
    cmd_t        cmd_reg;
    logic [6:0]  ac_reg;
    logic [5:0]  cg_reg;
    logic [5:0]  off_reg;
    logic        inc_reg, shift_reg, cur_reg, blink_reg, on_reg, tcg_reg;
    logic [4:0]  bits_reg;
    logic        hit_reg, line_ok_reg;

    // Memory ports
    logic        dd_we, pt_we;
    logic [6:0]  dd_addr;
    logic [7:0]  dd_wdata, dd_rdata;
    logic [10:0] pt_addr;
    logic [4:0]  pt_wdata, pt_rdata;

    clcd_ram #(.WIDTH(8), .DEPTH(128)) u_ddram (
        .aclk(aclk), .we(dd_we), .addr(dd_addr), .wdata(dd_wdata), .rdata(dd_rdata)
    );
    clcd_ram #(.WIDTH(5), .DEPTH(2048)) u_pat (
        .aclk(aclk), .we(pt_we), .addr(pt_addr), .wdata(pt_wdata), .rdata(pt_rdata)
    );

    // Counter stepping helpers
    function automatic logic [6:0] ac_up(input logic [6:0] a);
        if (a >= LINE2_LAST) return a;
        if (a == LINE1_LAST) return LINE2_BASE;
        return a + 7'd1;
    endfunction
    function automatic logic [6:0] ac_down(input logic [6:0] a);
        if (a == 7'd0) return a;
        if (a == LINE2_BASE) return LINE1_LAST;
        return a - 7'd1;
    endfunction

    // Read address decode
    logic       rd_line;
    logic [7:0] rd_col;
    logic [7:0] rd_addr;
    logic [7:0] cur_lin;
    logic       cur_hit;
    assign rd_line = ({3'd0, cmd_reg.cell_req} >= NCELL);
    assign rd_col  = rd_line ? ({3'd0, cmd_reg.cell_req} - NCELL) : {3'd0, cmd_reg.cell_req};
    assign rd_addr = (rd_line ? {1'b0, LINE2_BASE} : 8'd0) + {2'd0, off_reg} + rd_col;

    // Cursor screen cell match
    always_comb begin
        cur_lin = 8'd0;
        cur_hit = 1'b0;
        if ({1'b0, ac_reg} >= {2'd0, off_reg} &&
            {1'b0, ac_reg} < {2'd0, off_reg} + NCELL) begin
            cur_hit = ({1'b0, ac_reg} - {2'd0, off_reg}) == rd_col && !rd_line;
        end else if ({1'b0, ac_reg} >= {1'b0, LINE2_BASE} + {2'd0, off_reg} &&
                     {1'b0, ac_reg} < {1'b0, LINE2_BASE} + {2'd0, off_reg} + NCELL) begin
            cur_lin = {1'b0, ac_reg} - {1'b0, LINE2_BASE} - {2'd0, off_reg};
            cur_hit = (cur_lin == rd_col) && rd_line;
        end
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = (state_reg == ST_OUT);
    assign m_row_bits = bits_reg;
    assign m_address_counter = ac_reg;

    // Memory port control
    always_comb begin
        dd_we = 1'b0;
        dd_addr = ac_reg;
        dd_wdata = cmd_reg.value;
        pt_we = 1'b0;
        pt_addr = {cmd_reg.char_code, cmd_reg.pixel_row};
        pt_wdata = cmd_reg.value[4:0];
        case (state_reg)
            ST_INIT: begin
                dd_we = (sweep_reg < 11'd128);
                dd_addr = sweep_reg[6:0];
                dd_wdata = BLANK_CODE;
                pt_we = 1'b1;
                pt_addr = sweep_reg;
                pt_wdata = 5'd0;
            end
            ST_CLR: begin
                dd_we = 1'b1;
                dd_addr = sweep_reg[6:0];
                dd_wdata = BLANK_CODE;
            end
            ST_EXEC: begin
                if (cmd_reg.action == ACT_DATA) begin
                    if (tcg_reg) begin
                        pt_we = 1'b1;
                        pt_addr = {5'd0, cg_reg};
                    end else begin
                        dd_we = 1'b1;
                    end
                end else if (cmd_reg.action == ACT_LOAD) begin
                    pt_we = 1'b1;
                end else if (cmd_reg.action == ACT_READ) begin
                    dd_addr = rd_addr[6:0];
                end
            end
            ST_RD1: dd_addr = rd_addr[6:0];
            ST_RD2: pt_addr = {dd_rdata, cmd_reg.pixel_row};
            default: ;
        endcase
    end

    // Sequence each command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            sweep_reg <= 11'd0;
            ac_reg <= 7'd0; cg_reg <= 6'd0; off_reg <= 6'd0;
            inc_reg <= 1'b1; shift_reg <= 1'b0; cur_reg <= 1'b0;
            blink_reg <= 1'b0; on_reg <= 1'b1; tcg_reg <= 1'b0;
            bits_reg <= 5'd0;
        end else begin
            case (state_reg)
                ST_INIT: begin
                    sweep_reg <= sweep_reg + 11'd1;
                    if (sweep_reg == 11'd2047) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg <= q_cmd;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    bits_reg <= 5'd0;
                    state_reg <= ST_OUT;
                    case (cmd_reg.action)
                        ACT_INSTR: begin
                            if (cmd_reg.value[7]) begin
                                ac_reg <= cmd_reg.value[6:0];
                                tcg_reg <= 1'b0;
                            end else if (cmd_reg.value[6]) begin
                                cg_reg <= cmd_reg.value[5:0];
                                tcg_reg <= 1'b1;
                            end else if (cmd_reg.value[5]) begin
                            end else if (cmd_reg.value[4]) begin
                                if (cmd_reg.value[3]) begin
                                    if (cmd_reg.value[2]) begin
                                        if (off_reg < MAXOFF) off_reg <= off_reg + 6'd1;
                                    end else if (off_reg != 6'd0) begin
                                        off_reg <= off_reg - 6'd1;
                                    end
                                end else begin
                                    ac_reg <= cmd_reg.value[2] ? ac_up(ac_reg) : ac_down(ac_reg);
                                end
                            end else if (cmd_reg.value[3]) begin
                                blink_reg <= cmd_reg.value[0];
                                cur_reg <= cmd_reg.value[1];
                                on_reg <= cmd_reg.value[2];
                            end else if (cmd_reg.value[2]) begin
                                inc_reg <= cmd_reg.value[1];
                                shift_reg <= cmd_reg.value[0];
                            end else if (cmd_reg.value[1]) begin
                                ac_reg <= 7'd0;
                                off_reg <= 6'd0;
                            end else if (cmd_reg.value[0]) begin
                                ac_reg <= 7'd0;
                                off_reg <= 6'd0;
                                sweep_reg <= 11'd0;
                                state_reg <= ST_CLR;
                            end
                        end
                        ACT_DATA: begin
                            if (tcg_reg) begin
                                cg_reg <= cg_reg + 6'd1;
                            end else if (inc_reg) begin
                                ac_reg <= ac_up(ac_reg);
                                if (shift_reg && off_reg < MAXOFF) off_reg <= off_reg + 6'd1;
                            end else begin
                                ac_reg <= ac_down(ac_reg);
                                if (shift_reg && off_reg != 6'd0) off_reg <= off_reg - 6'd1;
                            end
                        end
                        ACT_READ: state_reg <= ST_RD1;
                        default: ;
                    endcase
                end
                ST_RD1: begin
                    hit_reg <= cur_reg && (cmd_reg.blink_phase || !blink_reg) && cur_hit;
                    line_ok_reg <= on_reg && (cmd_reg.cell_req < 5'(2 * CELLS_PER_LINE)
                                   || 2 * CELLS_PER_LINE >= 32);
                    state_reg <= ST_RD2;
                end
                ST_RD2: state_reg <= ST_RD3;
                ST_RD3: begin
                    bits_reg <= !line_ok_reg ? 5'd0 : (hit_reg ? 5'h1F : pt_rdata);
                    state_reg <= ST_OUT;
                end
                ST_CLR: begin
                    // Walk 0x00..0x27 then 0x40..0x67
                    if (sweep_reg[6:0] == LINE1_LAST) sweep_reg <= {4'd0, LINE2_BASE};
                    else sweep_reg <= sweep_reg + 11'd1;
                    if (sweep_reg[6:0] == LINE2_LAST) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- design/character_lcd_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// character_lcd_controller
// 16x2 character display controller with display and pattern memories.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories before taking its first
// transaction from the queue. Each transaction yields one result, be it an
// instruction, data write, pattern load, pixel read or clear: a pixel read
// passes a registered display memory read and then a registered pattern
// read, and clear blanks both lines. A two-entry input queue keeps accepting,
// until it is full, while the engine works or waits on the result channel.
module character_lcd_controller #(
    parameter int CELLS_PER_LINE = clcd_pkg::CELLS_PER_LINE_DEF,
    parameter int MAX_OFFSET     = clcd_pkg::MAX_OFFSET_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_value,
    input  logic [4:0] s_cell_req,
    input  logic [2:0] s_pixel_row,
    input  logic [7:0] s_char_code,
    input  logic       s_blink_phase,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_row_bits,
    output logic [6:0] m_address_counter
);
    import clcd_pkg::*;

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_pop;

    assign in_cmd = '{action: s_action, value: s_value, cell_req: s_cell_req,
                      pixel_row: s_pixel_row, char_code: s_char_code,
                      blink_phase: s_blink_phase};

    clcd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    clcd_back #(.CELLS_PER_LINE(CELLS_PER_LINE), .MAX_OFFSET(MAX_OFFSET)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop),
        .q_cmd(q_cmd), .m_valid(m_valid), .m_ready(m_ready),
        .m_row_bits(m_row_bits), .m_address_counter(m_address_counter)
    );

    // Counter held while the result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_address_counter))
        else $error("counter changed under stall");
    // Result held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_row_bits))
        else $error("result dropped");
    // Queue never pops when empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid) else $error("queue underflow");
endmodule
